FILE: rtl/core/tal_pkg.sv
package tal_pkg;

  // Sample window
  localparam int unsigned WINDOW      = 20;
  localparam int unsigned SLOT_W      = $clog2(WINDOW);
  localparam int unsigned SAMPLE_W    = 10;
  localparam int unsigned SAMPLE_MAX  = 1023;
  localparam int unsigned SUM_MAX     = WINDOW * SAMPLE_MAX;
  localparam int unsigned SUM_W       = $clog2(SUM_MAX + 1);

  // Floored mean: multiply by a rounded-up reciprocal, exact for every SUM_W-bit sum
  localparam int unsigned AVG_SH      = SUM_W + $clog2(WINDOW);
  localparam int unsigned AVG_RECIP_W = SUM_W + 1;
  localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
    AVG_RECIP_W'(((64'd1 << AVG_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam int unsigned AVG_PROD_W  = SUM_W + AVG_RECIP_W;

  // Volts: v = 32*t + floor((64*t + 1023) / 2046), t = 5*avg
  localparam int unsigned T_W         = 13;
  localparam int unsigned VX_W        = 19;
  localparam int unsigned VX_ROUND    = 1023;
  localparam int unsigned VQ_DIV      = 2046;
  localparam int unsigned VQ_SH       = VX_W + $clog2(VQ_DIV);
  localparam int unsigned VQ_RECIP_W  = 20;
  localparam logic [VQ_RECIP_W-1:0] VQ_RECIP =
    VQ_RECIP_W'(((64'd1 << VQ_SH) + 64'(VQ_DIV) - 64'd1) / 64'(VQ_DIV));
  localparam int unsigned VQ_PROD_W   = VX_W + VQ_RECIP_W;
  localparam int unsigned VQ_Q_W      = 8;
  localparam int unsigned V_W         = 18;

  // Cubic in signed Q16
  localparam int unsigned A_W         = 23;
  localparam int unsigned HM_W        = A_W + V_W + 1;
  localparam int unsigned FRAC_SH     = 16;
  localparam int signed   COEF3       = 56440;
  localparam int signed   COEF2       = -46032;
  localparam int signed   COEF1       = 919077;
  localparam int signed   COEF0       = -219755;
  localparam int unsigned HORNER_STEPS = 3;

  // Gain, 9/5 scale and offset
  localparam int unsigned GAIN_W      = 16;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd17203;
  localparam int unsigned P_W         = A_W + GAIN_W + 1;
  localparam int unsigned P9_W        = P_W + 4;
  localparam int unsigned SCALE_SH    = 22;
  localparam int unsigned Y_W         = P9_W - SCALE_SH;
  localparam int unsigned YB_W        = Y_W + 2;
  localparam int unsigned Y_OFFSET    = 1 << (Y_W - 1);
  localparam int unsigned Y_BIAS      = 5 * Y_OFFSET;
  localparam int unsigned D5_SH       = YB_W + 3;
  localparam int unsigned D5_RECIP_W  = YB_W + 1;
  localparam logic [D5_RECIP_W-1:0] D5_RECIP =
    D5_RECIP_W'(((64'd1 << D5_SH) + 64'd4) / 64'd5);
  localparam int unsigned D5_PROD_W   = YB_W + D5_RECIP_W;
  localparam int unsigned Q_W         = YB_W - 2;
  localparam int unsigned F_W         = Q_W + 2;
  localparam int signed   DEG32_Q8    = 8192;
  localparam int unsigned TEMP_W      = 16;
  localparam int unsigned TEMP_MAX    = 65535;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_AVG,
    S_VOLT,
    S_VDIV,
    S_VSUM,
    S_HORNER,
    S_GAIN,
    S_SCALE,
    S_DIV5,
    S_FINAL
  } state_t;

  function automatic logic signed [A_W-1:0] horner_coef(input logic [1:0] step);
    logic signed [A_W-1:0] c;
    unique case (step)
      2'd0:    c = A_W'(COEF2);
      2'd1:    c = A_W'(COEF1);
      2'd2:    c = A_W'(COEF0);
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/thermistor_average_linearizer.sv
// Thermistor averager and linearizer. Each accepted adc_sample beat replaces the
// oldest entry of a 20-entry ring (zeros after reset, and those zeros count in the
// mean until overwritten), updates the running sum, and yields one result beat:
// average_raw, the floored window mean, and temperature_f, the cubic linearization
// of that mean in volts, scaled by trim_gain (unsigned Q2.14) and 9/5, plus 32 F,
// in 1/256 degree F, clipped to 0..65535. One sample is in flight at a time: the
// next sample is accepted only after the ring write-back, the mean, volts and
// reciprocal divides, the Horner steps, the gain, scale and divide-by-5 steps and
// the final step that loads the result, each in its own state, have run and the
// block is back in idle; a stalled result holds the final step. The ring is a
// synchronous memory read at acceptance; per-entry valid bits make unwritten
// entries read as zero, so no clearing pass is needed after reset.
// trim_gain is written through cfg_we and cfg_wdata and resets to 1.05; the user
// must write it only while the block is idle, which the block itself does not enforce.
module thermistor_average_linearizer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tal_pkg::GAIN_W-1:0]         cfg_wdata,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  logic [tal_pkg::SAMPLE_W-1:0]       adc_sample,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [tal_pkg::TEMP_W-1:0]         temperature_f,
  output logic [tal_pkg::SAMPLE_W-1:0]       average_raw
);

  tal_pkg::state_t state, state_next;

  // Control
  logic                              accept;
  logic                              ring_we;
  logic                              out_load;
  logic                              horner_last;

  // Configuration and window state
  logic [tal_pkg::GAIN_W-1:0]        trim_gain;
  logic [tal_pkg::SLOT_W-1:0]        slot;
  logic [tal_pkg::SUM_W-1:0]         window_sum;
  logic [tal_pkg::SAMPLE_W-1:0]      ring_mem [tal_pkg::WINDOW];
  logic [tal_pkg::WINDOW-1:0]        ring_vld;
  logic [tal_pkg::SAMPLE_W-1:0]      ring_rd;
  logic [tal_pkg::SAMPLE_W-1:0]      sample_q;
  logic [tal_pkg::SAMPLE_W-1:0]      old_sample;

  // Datapath registers and combinational values
  logic [tal_pkg::AVG_PROD_W-1:0]    avg_prod;
  logic [tal_pkg::SAMPLE_W-1:0]      avg_q;
  logic [tal_pkg::SAMPLE_W-1:0]      avg_now;
  logic [tal_pkg::T_W-1:0]           t_q;
  logic [tal_pkg::T_W-1:0]           t_now;
  logic [tal_pkg::VX_W-1:0]          vx_q;
  logic [tal_pkg::VQ_PROD_W-1:0]     vq_prod;
  logic [tal_pkg::V_W-1:0]           v_q;
  logic signed [tal_pkg::A_W-1:0]    acc;
  logic [1:0]                        h_idx;
  logic signed [tal_pkg::HM_W-1:0]   h_mul;
  logic signed [tal_pkg::HM_W-1:0]   h_sum;
  logic signed [tal_pkg::P_W-1:0]    gain_prod;
  logic signed [tal_pkg::P9_W-1:0]   p9;
  logic signed [tal_pkg::YB_W:0]     yb_sum;
  logic [tal_pkg::YB_W-1:0]          yb_q;
  logic [tal_pkg::D5_PROD_W-1:0]     d5_prod;
  logic signed [tal_pkg::F_W-1:0]    f_val;

  assign accept = sample_valid && !sample_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tal_pkg::S_IDLE:   if (accept) state_next = tal_pkg::S_READ;
      tal_pkg::S_READ:   state_next = tal_pkg::S_AVG;
      tal_pkg::S_AVG:    state_next = tal_pkg::S_VOLT;
      tal_pkg::S_VOLT:   state_next = tal_pkg::S_VDIV;
      tal_pkg::S_VDIV:   state_next = tal_pkg::S_VSUM;
      tal_pkg::S_VSUM:   state_next = tal_pkg::S_HORNER;
      tal_pkg::S_HORNER: if (horner_last) state_next = tal_pkg::S_GAIN;
      tal_pkg::S_GAIN:   state_next = tal_pkg::S_SCALE;
      tal_pkg::S_SCALE:  state_next = tal_pkg::S_DIV5;
      tal_pkg::S_DIV5:   state_next = tal_pkg::S_FINAL;
      tal_pkg::S_FINAL:  if (out_load) state_next = tal_pkg::S_IDLE;
      default:           state_next = tal_pkg::S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    sample_stall = (state != tal_pkg::S_IDLE);
    ring_we      = (state == tal_pkg::S_READ);
    horner_last  = (h_idx == 2'(tal_pkg::HORNER_STEPS - 1));
    // hold the finished result until the output register is free
    out_load     = (state == tal_pkg::S_FINAL) && (!result_valid || !result_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tal_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_gain <= tal_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      trim_gain <= cfg_wdata;
    end
  end

  // Ring memory: read at acceptance, written back in the next cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      ring_rd <= ring_mem[slot];
    end
    if (ring_we) begin
      ring_mem[slot] <= sample_q;
    end
  end

  // An entry never written since reset counts as zero
  assign old_sample = ring_vld[slot] ? ring_rd : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_vld   <= '0;
      slot       <= '0;
      window_sum <= '0;
    end else if (ring_we) begin
      ring_vld[slot] <= 1'b1;
      window_sum     <= window_sum - tal_pkg::SUM_W'(old_sample)
                                   + tal_pkg::SUM_W'(sample_q);
      slot           <= (slot == tal_pkg::SLOT_W'(tal_pkg::WINDOW - 1)) ? '0
                                                                        : slot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= adc_sample;
    end
  end

  // Mean and volts
  assign avg_now = avg_prod[tal_pkg::AVG_SH +: tal_pkg::SAMPLE_W];
  assign t_now   = (tal_pkg::T_W'(avg_now) << 2) + tal_pkg::T_W'(avg_now);

  // Horner step: truncate the product toward minus infinity, add the next coefficient
  assign h_mul = acc * $signed({1'b0, v_q});
  assign h_sum = (h_mul >>> tal_pkg::FRAC_SH)
               + tal_pkg::HM_W'(tal_pkg::horner_coef(h_idx));

  // Times 9, floor by 2^22, bias so the divide by 5 sees a positive value
  assign p9     = (tal_pkg::P9_W'(gain_prod) <<< 3) + tal_pkg::P9_W'(gain_prod);
  assign yb_sum = (tal_pkg::YB_W + 1)'($signed(p9[tal_pkg::P9_W-1:tal_pkg::SCALE_SH]))
                + (tal_pkg::YB_W + 1)'(tal_pkg::Y_BIAS);

  assign f_val = $signed({2'b00, d5_prod[tal_pkg::D5_SH +: tal_pkg::Q_W]})
               - tal_pkg::F_W'(tal_pkg::Y_OFFSET)
               + tal_pkg::F_W'(tal_pkg::DEG32_Q8);

  always_ff @(posedge clk) begin
    unique case (state)
      tal_pkg::S_AVG: begin
        avg_prod <= tal_pkg::AVG_PROD_W'(window_sum) * tal_pkg::AVG_PROD_W'(tal_pkg::AVG_RECIP);
      end
      tal_pkg::S_VOLT: begin
        avg_q <= avg_now;
        t_q   <= t_now;
        vx_q  <= (tal_pkg::VX_W'(t_now) << 6) + tal_pkg::VX_W'(tal_pkg::VX_ROUND);
      end
      tal_pkg::S_VDIV: begin
        vq_prod <= tal_pkg::VQ_PROD_W'(vx_q) * tal_pkg::VQ_PROD_W'(tal_pkg::VQ_RECIP);
      end
      tal_pkg::S_VSUM: begin
        v_q   <= (tal_pkg::V_W'(t_q) << 5)
               + tal_pkg::V_W'(vq_prod[tal_pkg::VQ_SH +: tal_pkg::VQ_Q_W]);
        acc   <= tal_pkg::A_W'(tal_pkg::COEF3);
        h_idx <= '0;
      end
      tal_pkg::S_HORNER: begin
        acc   <= h_sum[tal_pkg::A_W-1:0];
        h_idx <= h_idx + 1'b1;
      end
      tal_pkg::S_GAIN: begin
        gain_prod <= acc * $signed({1'b0, trim_gain});
      end
      tal_pkg::S_SCALE: begin
        yb_q <= yb_sum[tal_pkg::YB_W-1:0];
      end
      tal_pkg::S_DIV5: begin
        d5_prod <= tal_pkg::D5_PROD_W'(yb_q) * tal_pkg::D5_PROD_W'(tal_pkg::D5_RECIP);
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      average_raw <= avg_q;
      priority if (f_val < 0) begin
        temperature_f <= '0;
      end else if (f_val > tal_pkg::F_W'(tal_pkg::TEMP_MAX)) begin
        temperature_f <= tal_pkg::TEMP_W'(tal_pkg::TEMP_MAX);
      end else begin
        temperature_f <= f_val[tal_pkg::TEMP_W-1:0];
      end
    end
  end

  // Checks
  sum_bounded: assert property (@(posedge clk) disable iff (rst)
    window_sum <= tal_pkg::SUM_W'(tal_pkg::SUM_MAX))
    else $error("window sum beyond the largest ring total");

  horner_count: assert property (@(posedge clk) disable iff (rst)
    (state == tal_pkg::S_HORNER) |-> (h_idx != 2'd3))
    else $error("Horner step count overran");

  result_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == tal_pkg::S_FINAL))
    else $error("result raised outside the final step");

  ring_written: assert property (@(posedge clk) disable iff (rst)
    (state == tal_pkg::S_READ) |=> ring_vld[$past(slot)])
    else $error("ring entry not marked after write-back");

endmodule
